[src/video_register_port_scroll_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the video register port
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VIDEO_REGISTER_PORT_SCROLL_MACROS_SVH
`define VIDEO_REGISTER_PORT_SCROLL_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define VRPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define VRPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/vrps_pkg.sv]
// ----------------------------------------------------------------------------
// vrps_pkg
// Codes, address constants and scroll helper functions of the register port.
// ----------------------------------------------------------------------------
package vrps_pkg;

  // Memory sizes
  localparam int NT_BYTES_DEF  = 2048;
  localparam int PATTERN_BYTES = 8192;
  localparam int SPRITE_BYTES  = 256;
  localparam int PAL_BYTES     = 32;
  localparam int PAT_AW        = $clog2(PATTERN_BYTES);
  localparam int SPR_AW        = $clog2(SPRITE_BYTES);
  localparam int PAL_AW        = $clog2(PAL_BYTES);

  // Item operation codes
  localparam logic [3:0] OP_READ     = 4'd0;
  localparam logic [3:0] OP_WRITE    = 4'd1;
  localparam logic [3:0] OP_VBLANK   = 4'd2;
  localparam logic [3:0] OP_PRE_CLR  = 4'd3;
  localparam logic [3:0] OP_SPR0_HIT = 4'd4;
  localparam logic [3:0] OP_OVERFLOW = 4'd5;
  localparam logic [3:0] OP_INC_X    = 4'd6;
  localparam logic [3:0] OP_INC_Y    = 4'd7;
  localparam logic [3:0] OP_COPY_X   = 4'd8;
  localparam logic [3:0] OP_COPY_Y   = 4'd9;

  // CPU-visible register indexes
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // Nametable mirroring modes
  localparam logic [1:0] MIR_HORZ = 2'd0;
  localparam logic [1:0] MIR_VERT = 2'd1;
  localparam logic [1:0] MIR_LOW  = 2'd2;
  localparam logic [1:0] MIR_HIGH = 2'd3;
  localparam logic [1:0] MIR_RESET = MIR_VERT;

  // Scroll copy masks
  localparam logic [15:0] COPY_X_KEEP = 16'hFBE0;
  localparam logic [15:0] COPY_X_TAKE = 16'h041F;
  localparam logic [15:0] COPY_Y_KEEP = 16'h841F;
  localparam logic [15:0] COPY_Y_TAKE = 16'h7BE0;
  localparam logic [15:0] PAL_BASE    = 16'h3F00;

  // One item's result
  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi_level;
    logic [15:0] current_address;
    logic [2:0]  fine_scroll_x;
    logic [7:0]  mask_value;
  } res_t;

  // Nametable byte index from address bits 11:0
  function automatic logic [10:0] nt_index(input logic [11:0] a, input logic [1:0] mode);
    logic [10:0] r;
    case (mode)
      MIR_HORZ: r = {a[11], a[9:0]};
      MIR_VERT: r = a[10:0];
      MIR_LOW:  r = {1'b0, a[9:0]};
      default:  r = {1'b1, a[9:0]};
    endcase
    return r;
  endfunction

  // Backdrop entries of the sprite palettes alias the background ones
  function automatic logic [PAL_AW-1:0] pal_index(input logic [4:0] a);
    logic [4:0] p;
    p = a;
    if (p[4] && (p[1:0] == 2'b00)) begin
      p[4] = 1'b0;
    end
    return p;
  endfunction

  // Coarse X step with horizontal nametable wrap
  function automatic logic [15:0] inc_x(input logic [15:0] v);
    logic [15:0] r;
    r = v;
    if (v[4:0] == 5'd31) begin
      r[4:0] = 5'd0;
      r[10]  = ~v[10];
    end else begin
      r = v + 16'd1;
    end
    return r;
  endfunction

  // Fine Y step, then coarse Y with vertical nametable wrap at row 29
  function automatic logic [15:0] inc_y(input logic [15:0] v);
    logic [15:0] r;
    logic [4:0]  y;
    r = v;
    y = v[9:5];
    if (v[14:12] != 3'd7) begin
      r = v + 16'h1000;
    end else begin
      r[14:12] = 3'd0;
      if (y == 5'd29) begin
        y     = 5'd0;
        r[11] = ~v[11];
      end else if (y == 5'd31) begin
        y = 5'd0;
      end else begin
        y = y + 5'd1;
      end
      r[9:5] = y;
    end
    return r;
  endfunction

endpackage

[src/vrps_ram.sv]
// ----------------------------------------------------------------------------
// vrps_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module vrps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/video_register_port_scroll.sv]
// ----------------------------------------------------------------------------
// video_register_port_scroll: CPU register port of a tile video processor
// Results are registered into the output register, or the skid slot while the
// output is stalled; sprite-data and video-data reads first do one synchronous
// RAM read. Throughput: 1 item/cycle, input stalled during RAM reads and skid full.
// Reset: synchronous, control registers to 0, mirroring to vertical; no RAM clear.
// ----------------------------------------------------------------------------
`include "video_register_port_scroll_macros.svh"

module video_register_port_scroll #(
  parameter int NAMETABLE_BYTES = vrps_pkg::NT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // mirroring mode register
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  // item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_operation,
  input  logic [2:0]  in_register_index,
  input  logic [7:0]  in_write_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_nmi_level,
  output logic [15:0] out_current_address,
  output logic [2:0]  out_fine_scroll_x,
  output logic [7:0]  out_mask_value
);

  import vrps_pkg::*;

  localparam int NT_AW = $clog2(NAMETABLE_BYTES);

  // ST_FETCH: a sprite or video RAM read is in flight, result follows
  typedef enum logic {ST_IDLE, ST_FETCH} state_t;
  // which RAM feeds the pending read
  typedef enum logic [1:0] {SRC_SPR, SRC_PAT, SRC_NT, SRC_PAL} src_t;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t      state_r,  state_nxt;
  logic [1:0]  mirror_r, mirror_nxt;
  logic [7:0]  ctrl_r,   ctrl_nxt;
  logic [7:0]  mask_r,   mask_nxt;
  logic [2:0]  status_r, status_nxt;   // [2] vblank, [1] sprite-0 hit, [0] overflow
  logic [7:0]  ptr_r,    ptr_nxt;      // sprite memory pointer
  logic [15:0] v_r,      v_nxt;        // current video address
  logic [15:0] t_r,      t_nxt;        // temporary address
  logic [2:0]  fx_r,     fx_nxt;       // fine X
  logic        w_r,      w_nxt;        // second-write toggle
  logic [7:0]  buf_r,    buf_nxt;      // data read buffer
  logic [7:0]  latch_r,  latch_nxt;    // bus latch
  logic        nmi_r,    nmi_nxt;

  // pending read bookkeeping
  src_t        pend_src_r,  pend_src_nxt;
  logic        pend_vram_r, pend_vram_nxt;  // data-port read (buffered)
  logic        pend_byp_r,  pend_byp_nxt;   // palette range bypasses the buffer

  // output register and skid slot
  res_t        out_r,  out_nxt;
  logic        out_vld_r, out_vld_nxt;
  res_t        skid_r, skid_nxt;
  logic        skid_vld_r, skid_vld_nxt;

  // --------------------------------------------------------------------------
  // Combinational signals
  // --------------------------------------------------------------------------
  logic        acc;         // input transfer this cycle
  logic        push;        // a result is produced this cycle
  logic        out_take;    // output transfer this cycle
  res_t        res;
  src_t        vram_src;    // region decode of v_r
  logic        rendering;
  logic [15:0] v_step;
  logic [7:0]  fetch_data;
  logic [7:0]  rd_val;

  logic        spr_we, pat_we, nt_we, pal_we;
  logic [7:0]  spr_rdata, pat_rdata, nt_rdata, pal_rdata;
  logic [NT_AW-1:0]  nt_addr;
  logic [PAL_AW-1:0] pal_addr;

  assign acc       = in_valid && !in_stall;
  assign out_take  = out_vld_r && !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || skid_vld_r;
  assign rendering = mask_r[4] || mask_r[3];
  assign v_step    = ctrl_r[2] ? (v_r + 16'd32) : (v_r + 16'd1);

  // Video memory map on v[13:0]: pattern below 0x2000, palette at 0x3F00 and
  // up, nametables in between.
  always_comb begin
    if (!v_r[13]) begin
      vram_src = SRC_PAT;
    end else if (v_r[13:8] != PAL_BASE[13:8]) begin
      vram_src = SRC_NT;
    end else begin
      vram_src = SRC_PAL;
    end
  end

  assign nt_addr  = NT_AW'(nt_index(v_r[11:0], mirror_r));
  assign pal_addr = pal_index(v_r[4:0]);

  // Read data of the RAM addressed by the pending read
  always_comb begin
    case (pend_src_r)
      SRC_SPR: fetch_data = spr_rdata;
      SRC_PAT: fetch_data = pat_rdata;
      SRC_NT:  fetch_data = nt_rdata;
      SRC_PAL: fetch_data = pal_rdata;
      default: fetch_data = spr_rdata;
    endcase
  end

  // --------------------------------------------------------------------------
  // Item decode: all port-state register updates, RAM writes and RAM read launches
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    mirror_nxt    = cfg_wr_en ? cfg_wr_data : mirror_r;
    ctrl_nxt      = ctrl_r;
    mask_nxt      = mask_r;
    status_nxt    = status_r;
    ptr_nxt       = ptr_r;
    v_nxt         = v_r;
    t_nxt         = t_r;
    fx_nxt        = fx_r;
    w_nxt         = w_r;
    buf_nxt       = buf_r;
    latch_nxt     = latch_r;
    nmi_nxt       = nmi_r;
    pend_src_nxt  = pend_src_r;
    pend_vram_nxt = pend_vram_r;
    pend_byp_nxt  = pend_byp_r;
    spr_we        = 1'b0;
    pat_we        = 1'b0;
    nt_we         = 1'b0;
    pal_we        = 1'b0;
    push          = 1'b0;
    rd_val        = latch_r;

    if (state_r == ST_FETCH) begin
      // RAM data is back: finish the read
      if (pend_vram_r) begin
        buf_nxt = fetch_data;
        rd_val  = pend_byp_r ? fetch_data : buf_r;
      end else begin
        rd_val  = fetch_data;
      end
      latch_nxt = rd_val;
      state_nxt = ST_IDLE;
      push      = 1'b1;
    end else if (acc) begin
      push = 1'b1;
      case (in_operation)
        OP_READ: begin
          case (in_register_index)
            REG_STATUS: begin
              rd_val        = {status_r, latch_r[4:0]};
              latch_nxt     = rd_val;
              status_nxt[2] = 1'b0;
              w_nxt         = 1'b0;
              nmi_nxt       = 1'b0;
            end
            REG_OAM_DATA: begin
              // sprite memory is addressed by ptr_r this cycle
              pend_src_nxt  = SRC_SPR;
              pend_vram_nxt = 1'b0;
              pend_byp_nxt  = 1'b0;
              state_nxt     = ST_FETCH;
              push          = 1'b0;
            end
            REG_DATA: begin
              // RAM reads at the old v; full 16-bit compare selects bypass
              pend_src_nxt  = vram_src;
              pend_vram_nxt = 1'b1;
              pend_byp_nxt  = (v_r >= PAL_BASE);
              v_nxt         = v_step;
              state_nxt     = ST_FETCH;
              push          = 1'b0;
            end
            default: begin
            end
          endcase
        end
        OP_WRITE: begin
          latch_nxt = in_write_data;
          case (in_register_index)
            REG_CTRL: begin
              ctrl_nxt       = in_write_data;
              t_nxt[11:10]   = in_write_data[1:0];
              if (in_write_data[7] && status_r[2]) begin
                nmi_nxt = 1'b1;
              end
            end
            REG_MASK: begin
              mask_nxt = in_write_data;
            end
            REG_OAM_ADDR: begin
              ptr_nxt = in_write_data;
            end
            REG_OAM_DATA: begin
              spr_we  = 1'b1;
              ptr_nxt = ptr_r + 8'd1;
            end
            REG_SCROLL: begin
              if (!w_r) begin
                fx_nxt       = in_write_data[2:0];
                t_nxt[4:0]   = in_write_data[7:3];
                w_nxt        = 1'b1;
              end else begin
                t_nxt[14:12] = in_write_data[2:0];
                t_nxt[9:5]   = in_write_data[7:3];
                w_nxt        = 1'b0;
              end
            end
            REG_ADDR: begin
              if (!w_r) begin
                t_nxt = {2'b00, in_write_data[5:0], t_r[7:0]};
                w_nxt = 1'b1;
              end else begin
                t_nxt = {t_r[15:8], in_write_data};
                v_nxt = {t_r[15:8], in_write_data};
                w_nxt = 1'b0;
              end
            end
            REG_DATA: begin
              case (vram_src)
                SRC_PAT: pat_we = 1'b1;
                SRC_NT:  nt_we  = 1'b1;
                SRC_PAL: pal_we = 1'b1;
                default: begin
                end
              endcase
              v_nxt = v_step;
            end
            default: begin
            end
          endcase
        end
        OP_VBLANK: begin
          status_nxt[2] = 1'b1;
          if (ctrl_r[7]) begin
            nmi_nxt = 1'b1;
          end
        end
        OP_PRE_CLR: begin
          status_nxt = 3'b000;
          nmi_nxt    = 1'b0;
        end
        OP_SPR0_HIT: begin
          status_nxt[1] = 1'b1;
        end
        OP_OVERFLOW: begin
          status_nxt[0] = 1'b1;
        end
        OP_INC_X: begin
          if (rendering) begin
            v_nxt = inc_x(v_r);
          end
        end
        OP_INC_Y: begin
          if (rendering) begin
            v_nxt = inc_y(v_r);
          end
        end
        OP_COPY_X: begin
          if (rendering) begin
            v_nxt = (v_r & COPY_X_KEEP) | (t_r & COPY_X_TAKE);
          end
        end
        OP_COPY_Y: begin
          if (rendering) begin
            v_nxt = (v_r & COPY_Y_KEEP) | (t_r & COPY_Y_TAKE);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result carries the state after the item; a read leaves its value in the
  // bus latch, so the latch covers both cases
  always_comb begin
    res.read_data       = latch_nxt;
    res.nmi_level       = nmi_nxt;
    res.current_address = v_nxt;
    res.fine_scroll_x   = fx_nxt;
    res.mask_value      = mask_nxt;
  end

  // --------------------------------------------------------------------------
  // Output register with skid slot: a new result lands in the skid slot while
  // the output is stalled, and input transfers pause while it is full or in ST_FETCH.
  // --------------------------------------------------------------------------
  always_comb begin
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      if (out_take) begin
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || out_take) begin
        out_nxt     = res;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = res;
        skid_vld_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r       <= out_nxt;
    skid_r      <= skid_nxt;
    pend_src_r  <= pend_src_nxt;
    pend_vram_r <= pend_vram_nxt;
    pend_byp_r  <= pend_byp_nxt;
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      mirror_r   <= MIR_RESET;
      ctrl_r     <= 8'h00;
      mask_r     <= 8'h00;
      status_r   <= 3'b000;
      ptr_r      <= 8'h00;
      v_r        <= 16'h0000;
      t_r        <= 16'h0000;
      fx_r       <= 3'd0;
      w_r        <= 1'b0;
      buf_r      <= 8'h00;
      latch_r    <= 8'h00;
      nmi_r      <= 1'b0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mirror_r   <= mirror_nxt;
      ctrl_r     <= ctrl_nxt;
      mask_r     <= mask_nxt;
      status_r   <= status_nxt;
      ptr_r      <= ptr_nxt;
      v_r        <= v_nxt;
      t_r        <= t_nxt;
      fx_r       <= fx_nxt;
      w_r        <= w_nxt;
      buf_r      <= buf_nxt;
      latch_r    <= latch_nxt;
      nmi_r      <= nmi_nxt;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_read_data       = out_r.read_data;
  assign out_nmi_level       = out_r.nmi_level;
  assign out_current_address = out_r.current_address;
  assign out_fine_scroll_x   = out_r.fine_scroll_x;
  assign out_mask_value      = out_r.mask_value;

  // --------------------------------------------------------------------------
  // Memories: each item touches at most one entry of one RAM
  // --------------------------------------------------------------------------
  vrps_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_spr_ram (
    .clk   (clk),
    .we    (spr_we),
    .addr  (ptr_r[SPR_AW-1:0]),
    .wdata (in_write_data),
    .rdata (spr_rdata)
  );

  vrps_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .addr  (v_r[PAT_AW-1:0]),
    .wdata (in_write_data),
    .rdata (pat_rdata)
  );

  vrps_ram #(.WIDTH(8), .DEPTH(NAMETABLE_BYTES)) u_nt_ram (
    .clk   (clk),
    .we    (nt_we),
    .addr  (nt_addr),
    .wdata (in_write_data),
    .rdata (nt_rdata)
  );

  vrps_ram #(.WIDTH(8), .DEPTH(PAL_BYTES)) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .addr  (pal_addr),
    .wdata (in_write_data),
    .rdata (pal_rdata)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `VRPS_ASSERT_SAME(a_skid_behind_out, skid_vld_r, out_vld_r, "skid slot full with output empty")
  `VRPS_ASSERT_SAME(a_skid_no_overrun, push, !skid_vld_r, "result produced with skid slot full")
  `VRPS_ASSERT_NEXT(a_fetch_one_cycle, state_r == ST_FETCH, state_r == ST_IDLE, "read held over one cycle")
  `VRPS_ASSERT_NEXT(a_direct_result, acc && (state_nxt == ST_IDLE), out_vld_r, "direct item gave no result")
  `VRPS_ASSERT_SAME(a_nmi_needs_vblank, $rose(nmi_r), status_r[2], "nmi raised outside vblank")

endmodule

[verif/tb_video_register_port_scroll.sv]
// ----------------------------------------------------------------------------
// tb_video_register_port_scroll
// Self-checking bench for the CPU register port of the tile video processor.
// Bus accesses and timing events are queued, sent through the valid/stall
// item channel and each result is compared with a cycle-free prediction of
// the port, one mirroring mode per phase.
// ----------------------------------------------------------------------------
module tb_video_register_port_scroll;
  timeunit 1ns;
  timeprecision 1ps;

  import vrps_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned GAP_PCT         = 20;
  localparam int unsigned ITEMS_PER_PHASE = 225;
  localparam int unsigned NUM_PHASES      = 5;
  localparam int unsigned SETTLE_CYCLES   = 4;

  // top of the unused operation codes (10..15 do nothing)
  localparam logic [3:0] OP_TOP_UNUSED = 4'd15;

  // status flag bits, shown as bits 7..5 of a status read
  localparam int VBL_BIT = 2;
  localparam int HIT_BIT = 1;
  localparam int OVF_BIT = 0;

  // flat view of video memory: pattern, then nametable, then palette
  localparam int NT_SLOT0   = PATTERN_BYTES;
  localparam int PAL_SLOT0  = NT_SLOT0 + NT_BYTES_DEF;
  localparam int VRAM_SLOTS = PAL_SLOT0 + PAL_BYTES;

  // one queued transfer together with the result it must produce
  typedef struct packed {
    logic [3:0] op;
    logic [2:0] reg_idx;
    logic [7:0] wdata;
    res_t       want;
  } port_xfer_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports
  // --------------------------------------------------------------------------
  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        cfg_wr_en         = 1'b0;
  logic [1:0]  cfg_wr_data       = MIR_RESET;
  logic        in_valid          = 1'b0;
  logic        in_stall;
  logic [3:0]  in_operation      = OP_READ;
  logic [2:0]  in_register_index = REG_CTRL;
  logic [7:0]  in_write_data     = 8'h00;
  logic        out_valid;
  logic        out_stall         = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_nmi_level;
  logic [15:0] out_current_address;
  logic [2:0]  out_fine_scroll_x;
  logic [7:0]  out_mask_value;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  video_register_port_scroll dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_register_index   (in_register_index),
    .in_write_data       (in_write_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_nmi_level       (out_nmi_level),
    .out_current_address (out_current_address),
    .out_fine_scroll_x   (out_fine_scroll_x),
    .out_mask_value      (out_mask_value)
  );

  // --------------------------------------------------------------------------
  // Port prediction state. It advances in transfer order while items are
  // queued; config only changes with nothing in flight, so the order on the
  // channel is the same order.
  // --------------------------------------------------------------------------
  logic [1:0]  mirror_mode = MIR_RESET;
  logic [7:0]  ctrl_q      = 8'h00;
  logic [7:0]  mask_q      = 8'h00;
  logic [2:0]  stat_flags  = 3'b000;
  logic [7:0]  oam_addr    = 8'h00;
  logic [15:0] vaddr       = 16'h0000;   // loopy v
  logic [15:0] taddr       = 16'h0000;   // loopy t
  logic [2:0]  fine_x      = 3'd0;
  logic        wr_toggle   = 1'b0;
  logic [7:0]  data_buf    = 8'h00;
  logic [7:0]  bus_byte    = 8'h00;
  logic        nmi_line    = 1'b0;

  logic [7:0]  oam     [SPRITE_BYTES];
  bit          oam_ok  [SPRITE_BYTES];   // entry has been stored at least once
  logic [7:0]  vram    [VRAM_SLOTS];
  bit          vram_ok [VRAM_SLOTS];

  // Physical slot behind a video address, after mirroring and palette folding
  function automatic int vram_slot(input logic [15:0] addr);
    logic [13:0] a;
    logic [10:0] nt;
    logic [4:0]  p;
    a = addr[13:0];
    if (a < 14'h2000) begin
      return int'(a);
    end
    if (a < 14'h3F00) begin
      case (mirror_mode)
        MIR_HORZ: nt = 11'(((a >> 1) & 14'h0400) | (a & 14'h03FF));
        MIR_VERT: nt = 11'(a & 14'h07FF);
        MIR_LOW:  nt = 11'(a & 14'h03FF);
        default:  nt = 11'((a & 14'h03FF) | 14'h0400);
      endcase
      return NT_SLOT0 + int'(nt);
    end
    // sprite backdrop entries land on the background ones
    p = a[4:0];
    if ((p & 5'h13) == 5'h10) begin
      p = p & 5'h0F;
    end
    return PAL_SLOT0 + int'(p);
  endfunction

  function automatic logic [15:0] vaddr_stride();
    return ctrl_q[2] ? 16'd32 : 16'd1;
  endfunction

  // coarse X with wrap into the neighbour nametable
  function automatic logic [15:0] next_coarse_x(input logic [15:0] v);
    logic [15:0] r;
    r = v;
    if (v[4:0] == 5'd31) begin
      r[4:0] = 5'd0;
      r[10]  = ~r[10];
    end else begin
      r = v + 16'd1;
    end
    return r;
  endfunction

  // fine Y, then coarse Y: row 29 flips the vertical nametable, 31 just wraps
  function automatic logic [15:0] next_fine_y(input logic [15:0] v);
    logic [15:0] r;
    logic [4:0]  row;
    r = v;
    if (v[14:12] != 3'd7) begin
      r = v + 16'h1000;
    end else begin
      r[14:12] = 3'd0;
      row = v[9:5];
      if (row == 5'd29) begin
        row   = 5'd0;
        r[11] = ~r[11];
      end else if (row == 5'd31) begin
        row = 5'd0;
      end else begin
        row = row + 5'd1;
      end
      r[9:5] = row;
    end
    return r;
  endfunction

  // Advance the port by one item and return what the result channel shows
  function automatic res_t predict_port(input logic [3:0] op, input logic [2:0] ri,
                                        input logic [7:0] d);
    res_t r;
    int   slot;
    logic scroll_on;
    scroll_on = mask_q[3] | mask_q[4];
    case (op)
      OP_READ: begin
        case (ri)
          REG_STATUS: begin
            bus_byte = {stat_flags, bus_byte[4:0]};
            stat_flags[VBL_BIT] = 1'b0;
            wr_toggle = 1'b0;
            nmi_line = 1'b0;
          end
          REG_OAM_DATA: bus_byte = oam[oam_addr];
          REG_DATA: begin
            // buffered read; from 0x3F00 up the fresh byte comes back at once
            slot = vram_slot(vaddr);
            bus_byte = data_buf;
            data_buf = vram[slot];
            if (vaddr >= PAL_BASE) begin
              bus_byte = data_buf;
            end
            vaddr = vaddr + vaddr_stride();
          end
          default: ;  // write-only registers answer with the bus latch
        endcase
      end
      OP_WRITE: begin
        bus_byte = d;
        case (ri)
          REG_CTRL: begin
            ctrl_q = d;
            taddr[11:10] = d[1:0];
            if (d[7] && stat_flags[VBL_BIT]) begin
              nmi_line = 1'b1;
            end
          end
          REG_MASK:     mask_q = d;
          REG_OAM_ADDR: oam_addr = d;
          REG_OAM_DATA: begin
            oam[oam_addr] = d;
            oam_ok[oam_addr] = 1'b1;
            oam_addr = oam_addr + 8'd1;
          end
          REG_SCROLL: begin
            if (!wr_toggle) begin
              fine_x = d[2:0];
              taddr[4:0] = d[7:3];
            end else begin
              taddr[14:12] = d[2:0];
              taddr[9:5] = d[7:3];
            end
            wr_toggle = ~wr_toggle;
          end
          REG_ADDR: begin
            if (!wr_toggle) begin
              taddr = {2'b00, d[5:0], taddr[7:0]};
            end else begin
              taddr[7:0] = d;
              vaddr = taddr;
            end
            wr_toggle = ~wr_toggle;
          end
          REG_DATA: begin
            slot = vram_slot(vaddr);
            vram[slot] = d;
            vram_ok[slot] = 1'b1;
            vaddr = vaddr + vaddr_stride();
          end
          default: ;  // status write only loads the latch
        endcase
      end
      OP_VBLANK: begin
        stat_flags[VBL_BIT] = 1'b1;
        if (ctrl_q[7]) begin
          nmi_line = 1'b1;
        end
      end
      OP_PRE_CLR: begin
        stat_flags = 3'b000;
        nmi_line = 1'b0;
      end
      OP_SPR0_HIT: stat_flags[HIT_BIT] = 1'b1;
      OP_OVERFLOW: stat_flags[OVF_BIT] = 1'b1;
      OP_INC_X:    if (scroll_on) vaddr = next_coarse_x(vaddr);
      OP_INC_Y:    if (scroll_on) vaddr = next_fine_y(vaddr);
      OP_COPY_X:   if (scroll_on) vaddr = (vaddr & COPY_X_KEEP) | (taddr & COPY_X_TAKE);
      OP_COPY_Y:   if (scroll_on) vaddr = (vaddr & COPY_Y_KEEP) | (taddr & COPY_Y_TAKE);
      default: ;  // unused codes are ignored
    endcase
    r.read_data       = bus_byte;
    r.nmi_level       = nmi_line;
    r.current_address = vaddr;
    r.fine_scroll_x   = fine_x;
    r.mask_value      = mask_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Queues and bookkeeping
  // --------------------------------------------------------------------------
  port_xfer_t  pending_xfers[$];     // waiting to be sent
  res_t        expected_results[$];  // sent, result not seen yet
  port_xfer_t  cur_xfer;             // on the input channel right now
  res_t        want_now;
  logic        in_taken = 1'b0;      // cur_xfer went through at the last edge
  logic        quiet = 1'b0;         // no gaps and no stalls while set
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Queue one item. A load of a sprite or video byte that was never stored
  // is turned into a store of the same byte, so no undefined entry is read.
  task automatic send(input logic [3:0] op, input logic [2:0] ri, input logic [7:0] d);
    port_xfer_t x;
    x.op      = op;
    x.reg_idx = ri;
    x.wdata   = d;
    if (op == OP_READ && ((ri == REG_OAM_DATA && !oam_ok[oam_addr]) ||
                          (ri == REG_DATA && !vram_ok[vram_slot(vaddr)]))) begin
      x.op = OP_WRITE;
    end
    x.want = predict_port(x.op, x.reg_idx, x.wdata);
    pending_xfers.push_back(x);
    items_queued++;
  endtask

  // Hold off until every queued item has been taken and answered
  task automatic drain();
    while (items_taken != items_queued || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Mostly well-formed access sequences with random content, some noise
  task automatic random_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned len;
    int unsigned pick;
    logic [15:0] a;
    logic [7:0]  b;
    stop_at = items_queued + n;
    while (items_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        // video memory: set an address, store a run, set it again, load it back
        len = $urandom_range(6, 1);
        case ($urandom_range(2))
          0:       a = 16'($urandom_range(16'h1FFF));
          1:       a = 16'($urandom_range(16'h3EFF, 16'h2000));
          default: a = 16'($urandom_range(16'h3FFF, 16'h3F00));
        endcase
        send(OP_READ, REG_STATUS, 8'($urandom_range(255)));
        send(OP_WRITE, REG_CTRL, 8'($urandom_range(255)));
        for (int rnd = 0; rnd < 2; rnd++) begin
          // top two bits of the high byte are dropped by the port
          send(OP_WRITE, REG_ADDR, {2'($urandom_range(3)), a[13:8]});
          send(OP_WRITE, REG_ADDR, a[7:0]);
          for (int k = 0; k < int'(len); k++) begin
            send(rnd == 0 ? OP_WRITE : OP_READ, REG_DATA, 8'($urandom_range(255)));
          end
        end
      end else if (pick < 50) begin
        // scroll setup, rendering on most of the time, then scroll events
        send(OP_READ, REG_STATUS, 8'($urandom_range(255)));
        send(OP_WRITE, REG_SCROLL, 8'($urandom_range(255)));
        send(OP_WRITE, REG_SCROLL, 8'($urandom_range(255)));
        send(OP_WRITE, REG_CTRL, 8'($urandom_range(255)));
        if ($urandom_range(1) != 0) begin
          send(OP_WRITE, REG_ADDR, 8'($urandom_range(255)));
          send(OP_WRITE, REG_ADDR, 8'($urandom_range(255)));
        end
        b = 8'($urandom_range(255));
        if ($urandom_range(4) != 0) begin
          b[3] = 1'b1;
        end
        send(OP_WRITE, REG_MASK, b);
        len = $urandom_range(16, 4);
        for (int k = 0; k < int'(len); k++) begin
          send(4'($urandom_range(OP_COPY_Y, OP_INC_X)), 3'($urandom_range(7)),
               8'($urandom_range(255)));
        end
      end else if (pick < 65) begin
        // sprite memory: store a run, point back into it, load
        b = 8'($urandom_range(255));
        len = $urandom_range(6, 1);
        send(OP_WRITE, REG_OAM_ADDR, b);
        for (int k = 0; k < int'(len); k++) begin
          send(OP_WRITE, REG_OAM_DATA, 8'($urandom_range(255)));
        end
        send(OP_WRITE, REG_OAM_ADDR, b + 8'($urandom_range(len - 1)));
        for (int k = 0; k < int'($urandom_range(3, 1)); k++) begin
          send(OP_READ, REG_OAM_DATA, 8'($urandom_range(255)));
        end
      end else if (pick < 75) begin
        // frame timing: vblank with nmi enable either way, flags, status poll
        send(OP_WRITE, REG_CTRL, 8'($urandom_range(255)));
        send(OP_VBLANK, 3'($urandom_range(7)), 8'($urandom_range(255)));
        if ($urandom_range(1) != 0) send(OP_WRITE, REG_CTRL, 8'($urandom_range(255)));
        if ($urandom_range(1) != 0) send(OP_SPR0_HIT, 3'($urandom_range(7)), 8'h00);
        if ($urandom_range(1) != 0) send(OP_OVERFLOW, 3'($urandom_range(7)), 8'h00);
        send(OP_READ, REG_STATUS, 8'($urandom_range(255)));
        if ($urandom_range(1) != 0) send(OP_READ, REG_STATUS, 8'h00);
        send(OP_PRE_CLR, 3'($urandom_range(7)), 8'($urandom_range(255)));
      end else begin
        // anything at all, unused op codes included
        send(4'($urandom_range(15)), 3'($urandom_range(7)), 8'($urandom_range(255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. A new transfer is loaded only
  // once the previous one went through; a held item keeps its payload.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (rst_n && pending_xfers.size() != 0 &&
          (quiet || $urandom_range(99) >= GAP_PCT)) begin
        cur_xfer = pending_xfers.pop_front();
        in_valid          <= 1'b1;
        in_operation      <= cur_xfer.op;
        in_register_index <= cur_xfer.reg_idx;
        in_write_data     <= cur_xfer.wdata;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !quiet && ($urandom_range(99) < GAP_PCT);
  end

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: both channels sampled on the rising edge. Results are checked
  // against the oldest expectation; an accepted item makes its expectation
  // outstanding.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with none outstanding, expected none, actual %0h",
                 $time, {out_read_data, out_nmi_level, out_current_address,
                         out_fine_scroll_x, out_mask_value});
      end else begin
        want_now = expected_results.pop_front();
        check_field("read_data", want_now.read_data, out_read_data);
        check_field("nmi_level", want_now.nmi_level, out_nmi_level);
        check_field("current_address", want_now.current_address, out_current_address);
        check_field("fine_scroll_x", want_now.fine_scroll_x, out_fine_scroll_x);
        check_field("mask_value", want_now.mask_value, out_mask_value);
      end
    end
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(cur_xfer.want);
      items_taken++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test
  // --------------------------------------------------------------------------
  initial begin
    logic [1:0] mode_sel;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, reset mirroring (vertical)
    send(OP_READ,  REG_CTRL,   8'h00);   // write-only register answers with latch
    send(OP_WRITE, REG_STATUS, 8'hFF);   // status write only loads the latch
    send(OP_READ,  REG_STATUS, 8'h00);   // flags clear, latch low bits show
    send(OP_VBLANK, REG_CTRL,  8'h00);   // nmi disabled: no nmi
    send(OP_WRITE, REG_CTRL,   8'h80);   // enabling nmi inside vblank raises it
    send(OP_SPR0_HIT, REG_CTRL, 8'h00);
    send(OP_OVERFLOW, REG_CTRL, 8'h00);
    send(OP_READ,  REG_STATUS, 8'h00);   // all three flags, clears vblank and nmi
    send(OP_PRE_CLR, REG_CTRL, 8'h00);
    send(OP_WRITE, REG_ADDR,   8'h3F);
    send(OP_WRITE, REG_ADDR,   8'h10);   // 0x3F10 aliases palette entry 0
    send(OP_WRITE, REG_DATA,   8'hA5);
    send(OP_WRITE, REG_ADDR,   8'hFF);   // high bits dropped
    send(OP_WRITE, REG_ADDR,   8'h00);
    send(OP_READ,  REG_DATA,   8'hFF);   // palette read bypasses the buffer
    send(OP_WRITE, REG_CTRL,   8'h04);   // step 32; no nmi since vblank is gone
    send(OP_WRITE, REG_MASK,   8'h18);   // rendering on
    send(OP_WRITE, REG_SCROLL, 8'hFF);
    send(OP_WRITE, REG_SCROLL, 8'hFF);
    send(OP_INC_X, REG_DATA,   8'h00);
    send(OP_INC_Y, REG_DATA,   8'h00);
    send(OP_COPY_X, REG_DATA,  8'h00);
    send(OP_COPY_Y, REG_DATA,  8'h00);
    send(OP_TOP_UNUSED, REG_DATA, 8'hFF);
    send(OP_WRITE, REG_OAM_ADDR, 8'hFF);
    send(OP_WRITE, REG_OAM_DATA, 8'h5A); // pointer wraps to 0
    send(OP_WRITE, REG_OAM_ADDR, 8'hFF);
    send(OP_READ,  REG_OAM_DATA, 8'h00);
    drain();

    // Random phases, one mirroring mode each; the mode only changes once
    // everything sent has been answered. Phase 2 runs without gaps or stalls.
    for (int ph = 0; ph < int'(NUM_PHASES); ph++) begin
      case (ph)
        0:       mode_sel = MIR_HORZ;
        1:       mode_sel = MIR_HIGH;
        2:       mode_sel = MIR_LOW;
        3:       mode_sel = MIR_VERT;
        default: mode_sel = 2'($urandom_range(3));
      endcase
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= mode_sel;
      mirror_mode = mode_sel;
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      quiet = (ph == 2);
      random_traffic(ITEMS_PER_PHASE);
      drain();
    end
    quiet = 1'b0;

    // catch any stray result after the last one
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[video_register_port_scroll.f]
+incdir+src
src/vrps_pkg.sv
src/vrps_ram.sv
src/video_register_port_scroll.sv
verif/tb_video_register_port_scroll.sv
